// File: sv/assert_macros.svh
// Assertion helpers shared by the checker files.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/jcct_pkg.sv
// ----------------------------------------------------------------------------
// JSON lexer transition package
// State, character class and action codes, the result struct and the table
// for the letter-by-letter word states.
// ----------------------------------------------------------------------------
package jcct_pkg;

  typedef enum logic [4:0] {
    ST_START  = 5'd0,
    ST_VALUE  = 5'd1,
    ST_ENDVAL = 5'd2,
    ST_KEY    = 5'd3,
    ST_STRING = 5'd4,
    ST_INT    = 5'd5,
    ST_FRAC   = 5'd6,
    ST_EXPBEG = 5'd7,
    ST_EXPDIG = 5'd8,
    ST_T1     = 5'd9,
    ST_T2     = 5'd10,
    ST_T3     = 5'd11,
    ST_N1     = 5'd12,
    ST_N2     = 5'd13,
    ST_N3     = 5'd14,
    ST_F1     = 5'd15,
    ST_F2     = 5'd16,
    ST_F3     = 5'd17,
    ST_F4     = 5'd18,
    ST_A1     = 5'd19,
    ST_A2     = 5'd20,
    ST_A3     = 5'd21,
    ST_A4     = 5'd22,
    ST_A5     = 5'd23,
    ST_MATRIX = 5'd24,
    ST_ERROR  = 5'd25
  } state_e;

  typedef enum logic [4:0] {
    CL_SPACE  = 5'd0,
    CL_WHITE  = 5'd1,
    CL_LBRACE = 5'd2,
    CL_RBRACE = 5'd3,
    CL_LBRACK = 5'd4,
    CL_RBRACK = 5'd5,
    CL_LPAREN = 5'd6,
    CL_RPAREN = 5'd7,
    CL_COLON  = 5'd8,
    CL_COMMA  = 5'd9,
    CL_DQUOTE = 5'd10,
    CL_PLUS   = 5'd11,
    CL_MINUS  = 5'd12,
    CL_DOT    = 5'd13,
    CL_ZERO   = 5'd14,
    CL_DIGIT  = 5'd15,
    CL_A      = 5'd16,
    CL_E      = 5'd17,
    CL_F      = 5'd18,
    CL_L      = 5'd19,
    CL_N      = 5'd20,
    CL_R      = 5'd21,
    CL_S      = 5'd22,
    CL_T      = 5'd23,
    CL_U      = 5'd24,
    CL_Y      = 5'd25,
    CL_BIGE   = 5'd26,
    CL_EOF    = 5'd27,
    CL_OTHER  = 5'd28
  } class_e;

  typedef enum logic [4:0] {
    AC_CONSUME = 5'd0,
    AC_RCHAR   = 5'd1,
    AC_BOBJ    = 5'd2,
    AC_BARR    = 5'd3,
    AC_EOBJ    = 5'd4,
    AC_EARR    = 5'd5,
    AC_NEXT    = 5'd6,
    AC_RKEY    = 5'd7,
    AC_EFILE   = 5'd8,
    AC_RSTR    = 5'd9,
    AC_RINT    = 5'd10,
    AC_RFLT    = 5'd11,
    AC_RNULL   = 5'd12,
    AC_RFALSE  = 5'd13,
    AC_RTRUE   = 5'd14,
    AC_BMAT    = 5'd15,
    AC_EMAT    = 5'd16,
    AC_ABORT   = 5'd17
  } action_e;

  typedef struct packed {
    state_e  next_state;
    action_e first_action;
    action_e second_action;
    logic    has_second;
  } trans_t;

  typedef struct packed {
    class_e  expect_class;
    state_e  match_state;
    action_e match_action;
  } word_t;

  localparam int unsigned WordCount = 15;

  // Indexed by state minus ST_T1.
  localparam word_t WORD_TAB [WordCount] = '{
    '{CL_R,      ST_T2,     AC_CONSUME},
    '{CL_U,      ST_T3,     AC_CONSUME},
    '{CL_E,      ST_ENDVAL, AC_RTRUE},
    '{CL_U,      ST_N2,     AC_CONSUME},
    '{CL_L,      ST_N3,     AC_CONSUME},
    '{CL_L,      ST_ENDVAL, AC_RNULL},
    '{CL_A,      ST_F2,     AC_CONSUME},
    '{CL_L,      ST_F3,     AC_CONSUME},
    '{CL_S,      ST_F4,     AC_CONSUME},
    '{CL_E,      ST_ENDVAL, AC_RFALSE},
    '{CL_R,      ST_A2,     AC_CONSUME},
    '{CL_R,      ST_A3,     AC_CONSUME},
    '{CL_A,      ST_A4,     AC_CONSUME},
    '{CL_Y,      ST_A5,     AC_CONSUME},
    '{CL_LPAREN, ST_MATRIX, AC_CONSUME}
  };

endpackage

// File: sv/jcct_decode.sv
// ----------------------------------------------------------------------------
// JSON lexer transition decode
// Combinational next-state and action decode for one state and one class.
// ----------------------------------------------------------------------------
module jcct_decode import jcct_pkg::*; (
  input  state_e     state_i,
  input  logic [4:0] char_class_i,
  output trans_t     trans_o
);

  class_e     cls;
  logic       ws;
  logic       digit;
  logic       num_start;
  logic [3:0] word_off;
  word_t      word;

  function automatic trans_t go1(state_e s, action_e a);
    trans_t t;
    t.next_state    = s;
    t.first_action  = a;
    t.second_action = AC_CONSUME;
    t.has_second    = 1'b0;
    return t;
  endfunction

  function automatic trans_t go2(state_e s, action_e a, action_e b);
    trans_t t;
    t.next_state    = s;
    t.first_action  = a;
    t.second_action = b;
    t.has_second    = 1'b1;
    return t;
  endfunction

  // Common ending of a number: record it, then close or move on.
  function automatic trans_t num_end(class_e c, action_e rec);
    trans_t t;
    t = go1(ST_ERROR, AC_ABORT);
    if (c == CL_RBRACE) t = go2(ST_ENDVAL, rec, AC_EOBJ);
    else if (c == CL_RBRACK) t = go2(ST_ENDVAL, rec, AC_EARR);
    else if (c == CL_COMMA) t = go2(ST_VALUE, rec, AC_NEXT);
    return t;
  endfunction

  assign cls       = (char_class_i > 5'(CL_OTHER)) ? CL_OTHER : class_e'(char_class_i);
  assign ws        = (cls == CL_SPACE) || (cls == CL_WHITE);
  assign digit     = (cls == CL_ZERO) || (cls == CL_DIGIT);
  assign num_start = digit || (cls == CL_MINUS) || (cls == CL_PLUS);
  assign word_off  = 4'(5'(state_i) - 5'(ST_T1));
  assign word      = WORD_TAB[word_off];

  always_comb begin
    trans_o = go1(ST_ERROR, AC_ABORT);
    case (state_i)
      ST_START: begin
        if (ws) trans_o = go1(ST_START, AC_CONSUME);
        else if (cls == CL_LBRACE) trans_o = go1(ST_KEY, AC_BOBJ);
        else if (cls == CL_LBRACK) trans_o = go1(ST_VALUE, AC_BARR);
      end
      ST_VALUE: begin
        if (ws) trans_o = go1(ST_VALUE, AC_CONSUME);
        else if (cls == CL_LBRACE) trans_o = go1(ST_KEY, AC_BOBJ);
        else if (cls == CL_LBRACK) trans_o = go1(ST_VALUE, AC_BARR);
        else if (cls == CL_DQUOTE) trans_o = go1(ST_STRING, AC_CONSUME);
        else if (cls == CL_A) trans_o = go1(ST_A1, AC_CONSUME);
        else if (num_start) trans_o = go1(ST_INT, AC_RCHAR);
        else if (cls == CL_DOT) trans_o = go1(ST_FRAC, AC_RCHAR);
        else if (cls == CL_T) trans_o = go1(ST_T1, AC_CONSUME);
        else if (cls == CL_F) trans_o = go1(ST_F1, AC_CONSUME);
        else if (cls == CL_N) trans_o = go1(ST_N1, AC_CONSUME);
        else if (cls == CL_RBRACK) trans_o = go1(ST_ENDVAL, AC_EARR);
      end
      ST_ENDVAL: begin
        if (ws) trans_o = go1(ST_ENDVAL, AC_CONSUME);
        else if (cls == CL_RBRACE) trans_o = go1(ST_ENDVAL, AC_EOBJ);
        else if (cls == CL_RBRACK) trans_o = go1(ST_ENDVAL, AC_EARR);
        else if (cls == CL_COMMA) trans_o = go1(ST_VALUE, AC_NEXT);
        else if (cls == CL_COLON) trans_o = go1(ST_VALUE, AC_RKEY);
        else if (cls == CL_EOF) trans_o = go1(ST_ENDVAL, AC_EFILE);
      end
      ST_KEY: begin
        if (ws) trans_o = go1(ST_KEY, AC_CONSUME);
        else if (cls == CL_DQUOTE) trans_o = go1(ST_STRING, AC_CONSUME);
      end
      ST_STRING: begin
        if (cls == CL_DQUOTE) trans_o = go1(ST_ENDVAL, AC_RSTR);
        else trans_o = go1(ST_STRING, AC_RCHAR);
      end
      ST_INT: begin
        if (digit) trans_o = go1(ST_INT, AC_RCHAR);
        else if (cls == CL_DOT) trans_o = go1(ST_FRAC, AC_RCHAR);
        else if (cls == CL_E || cls == CL_BIGE) trans_o = go1(ST_EXPBEG, AC_RCHAR);
        else trans_o = num_end(cls, AC_RINT);
      end
      ST_FRAC: begin
        if (digit) trans_o = go1(ST_FRAC, AC_RCHAR);
        else if (cls == CL_E || cls == CL_BIGE) trans_o = go1(ST_EXPBEG, AC_RCHAR);
        else trans_o = num_end(cls, AC_RFLT);
      end
      ST_EXPBEG: begin
        if (num_start) trans_o = go1(ST_EXPDIG, AC_RCHAR);
      end
      ST_EXPDIG: begin
        if (digit) trans_o = go1(ST_EXPDIG, AC_RCHAR);
        else trans_o = num_end(cls, AC_RFLT);
      end
      ST_MATRIX: begin
        if (cls == CL_RPAREN) trans_o = go1(ST_ENDVAL, AC_EMAT);
        else trans_o = go1(ST_MATRIX, AC_CONSUME);
      end
      ST_T1, ST_T2, ST_T3, ST_N1, ST_N2, ST_N3, ST_F1, ST_F2, ST_F3, ST_F4,
      ST_A1, ST_A2, ST_A3, ST_A4, ST_A5: begin
        // Spelled words advance one letter at a time; "array(" opens a matrix.
        if (cls == word.expect_class) begin
          if (state_i == ST_A5) trans_o = go2(word.match_state, word.match_action, AC_BMAT);
          else trans_o = go1(word.match_state, word.match_action);
        end
      end
      default: begin
        trans_o = go1(ST_ERROR, AC_ABORT);
      end
    endcase
  end

endmodule

// File: sv/json_char_class_transition_unit.sv
// ----------------------------------------------------------------------------
// JSON character class transition unit
// Keeps the lexer state and turns each classified character into the next
// state and one or two actions.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+------------------------------------
//   in      | in_valid_i | in_stall_o  | char_class_i
//   out     | out_valid_o| out_stall_i | next_state_o, first_action_o,
//           |            |             | second_action_o, has_second_o
//
// One item per cycle while the output is not stalled; each result is registered after the decode.
// The rate is set by the single decode between the input and result registers.
// Reset puts the lexer in the start state and empties both registers.
// A stall on the output holds the result; the input stalls only when the
// input register is full and cannot move on.
// ----------------------------------------------------------------------------
module json_char_class_transition_unit import jcct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [4:0] char_class_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [4:0] next_state_o,
  output logic [4:0] first_action_o,
  output logic [4:0] second_action_o,
  output logic       has_second_o
);

  logic       in_v_q;
  logic [4:0] cls_q;
  logic       out_v_q;
  trans_t     res_q;
  state_e     state_q;
  trans_t     trans;
  logic       advance;
  logic       in_take;

  jcct_decode u_decode (
    .state_i      (state_q),
    .char_class_i (cls_q),
    .trans_o      (trans)
  );

  assign advance    = in_v_q && (!out_v_q || !out_stall_i);
  assign in_stall_o = in_v_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      state_q <= ST_START;
    end else begin
      if (in_take) in_v_q <= 1'b1;
      else if (advance) in_v_q <= 1'b0;
      if (advance) begin
        out_v_q <= 1'b1;
        state_q <= trans.next_state;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) cls_q <= char_class_i;
    if (advance) res_q <= trans;
  end

  assign out_valid_o     = out_v_q;
  assign next_state_o    = 5'(res_q.next_state);
  assign first_action_o  = 5'(res_q.first_action);
  assign second_action_o = 5'(res_q.second_action);
  assign has_second_o    = res_q.has_second;

endmodule

// File: sv/jcct_checker.sv
// ----------------------------------------------------------------------------
// JSON lexer transition checker
// Port-level checks on the transition unit, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jcct_checker import jcct_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [4:0] char_class_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [4:0] next_state_o,
  input logic [4:0] first_action_o,
  input logic [4:0] second_action_o,
  input logic       has_second_o
);

  logic err_seen_q;

  // Set once an error result has been delivered; the lexer never leaves it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && next_state_o == 5'(ST_ERROR)) begin
      err_seen_q <= 1'b1;
    end
  end

  `ASSERT_IMPL(a_single_action_clean, out_valid_o && !has_second_o,
               second_action_o == 5'(AC_CONSUME))
  `ASSERT_IMPL(a_error_aborts, out_valid_o && next_state_o == 5'(ST_ERROR),
               first_action_o == 5'(AC_ABORT) && !has_second_o)
  `ASSERT_IMPL(a_error_sticks, out_valid_o && err_seen_q,
               next_state_o == 5'(ST_ERROR))
  `ASSERT_IMPL(a_no_stall_when_drained, !out_stall_i, !in_stall_o)
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
               out_valid_o && $stable(next_state_o) && $stable(first_action_o))

endmodule

bind json_char_class_transition_unit jcct_checker u_jcct_checker (.*);

// File: verif/lexer_transition_checker.sv
// ----------------------------------------------------------------------------
// JSON lexer transition checker
// Watches both channels of the transition unit. It keeps its own copy of the
// lexer state, works out the expected transition for every item taken in,
// and compares every result that leaves, field by field, in order.
// ----------------------------------------------------------------------------
module lexer_transition_checker import jcct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [4:0]  char_class_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [4:0]  next_state_i,
  input  logic [4:0]  first_action_i,
  input  logic [4:0]  second_action_i,
  input  logic        has_second_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o
);

  state_e      lexer_state;
  trans_t      expected_trans [$];
  int unsigned taken_cnt;

  assign pending_o = taken_cnt - results_o;

  function automatic trans_t one(state_e st, action_e act);
    trans_t t;
    t.next_state    = st;
    t.first_action  = act;
    t.second_action = AC_CONSUME;
    t.has_second    = 1'b0;
    return t;
  endfunction

  function automatic trans_t two(state_e st, action_e act, action_e act2);
    trans_t t;
    t = one(st, act);
    t.second_action = act2;
    t.has_second    = 1'b1;
    return t;
  endfunction

  // A number ends only on a closing bracket or a comma, recording itself first.
  function automatic trans_t number_exit(class_e c, action_e rec);
    case (c)
      CL_RBRACE: return two(ST_ENDVAL, rec, AC_EOBJ);
      CL_RBRACK: return two(ST_ENDVAL, rec, AC_EARR);
      CL_COMMA:  return two(ST_VALUE, rec, AC_NEXT);
      default:   return one(ST_ERROR, AC_ABORT);
    endcase
  endfunction

  function automatic trans_t next_transition(state_e st, logic [4:0] raw);
    class_e c;
    logic   ws;
    logic   digit;
    trans_t t;
    c     = (raw > CL_OTHER) ? CL_OTHER : class_e'(raw);
    ws    = (c == CL_SPACE) || (c == CL_WHITE);
    digit = (c == CL_ZERO) || (c == CL_DIGIT);
    t     = one(ST_ERROR, AC_ABORT);
    case (st)
      ST_START: begin
        if (ws) t = one(ST_START, AC_CONSUME);
        else if (c == CL_LBRACE) t = one(ST_KEY, AC_BOBJ);
        else if (c == CL_LBRACK) t = one(ST_VALUE, AC_BARR);
      end
      ST_VALUE: begin
        if (ws) t = one(ST_VALUE, AC_CONSUME);
        else if (c == CL_LBRACE) t = one(ST_KEY, AC_BOBJ);
        else if (c == CL_LBRACK) t = one(ST_VALUE, AC_BARR);
        else if (c == CL_DQUOTE) t = one(ST_STRING, AC_CONSUME);
        else if (c == CL_A) t = one(ST_A1, AC_CONSUME);
        else if (c == CL_MINUS || c == CL_PLUS || digit) t = one(ST_INT, AC_RCHAR);
        else if (c == CL_DOT) t = one(ST_FRAC, AC_RCHAR);
        else if (c == CL_T) t = one(ST_T1, AC_CONSUME);
        else if (c == CL_F) t = one(ST_F1, AC_CONSUME);
        else if (c == CL_N) t = one(ST_N1, AC_CONSUME);
        else if (c == CL_RBRACK) t = one(ST_ENDVAL, AC_EARR);
      end
      ST_ENDVAL: begin
        if (ws) t = one(ST_ENDVAL, AC_CONSUME);
        else if (c == CL_RBRACE) t = one(ST_ENDVAL, AC_EOBJ);
        else if (c == CL_RBRACK) t = one(ST_ENDVAL, AC_EARR);
        else if (c == CL_COMMA) t = one(ST_VALUE, AC_NEXT);
        else if (c == CL_COLON) t = one(ST_VALUE, AC_RKEY);
        else if (c == CL_EOF) t = one(ST_ENDVAL, AC_EFILE);
      end
      ST_KEY: begin
        if (ws) t = one(ST_KEY, AC_CONSUME);
        else if (c == CL_DQUOTE) t = one(ST_STRING, AC_CONSUME);
      end
      // No escapes: only a double quote closes the string.
      ST_STRING: t = (c == CL_DQUOTE) ? one(ST_ENDVAL, AC_RSTR) : one(ST_STRING, AC_RCHAR);
      ST_INT: begin
        if (digit) t = one(ST_INT, AC_RCHAR);
        else if (c == CL_DOT) t = one(ST_FRAC, AC_RCHAR);
        else if (c == CL_E || c == CL_BIGE) t = one(ST_EXPBEG, AC_RCHAR);
        else t = number_exit(c, AC_RINT);
      end
      ST_FRAC: begin
        if (digit) t = one(ST_FRAC, AC_RCHAR);
        else if (c == CL_E || c == CL_BIGE) t = one(ST_EXPBEG, AC_RCHAR);
        else t = number_exit(c, AC_RFLT);
      end
      ST_EXPBEG: if (c == CL_MINUS || c == CL_PLUS || digit) t = one(ST_EXPDIG, AC_RCHAR);
      ST_EXPDIG: t = digit ? one(ST_EXPDIG, AC_RCHAR) : number_exit(c, AC_RFLT);
      ST_T1: if (c == CL_R) t = one(ST_T2, AC_CONSUME);
      ST_T2: if (c == CL_U) t = one(ST_T3, AC_CONSUME);
      ST_T3: if (c == CL_E) t = one(ST_ENDVAL, AC_RTRUE);
      ST_N1: if (c == CL_U) t = one(ST_N2, AC_CONSUME);
      ST_N2: if (c == CL_L) t = one(ST_N3, AC_CONSUME);
      ST_N3: if (c == CL_L) t = one(ST_ENDVAL, AC_RNULL);
      ST_F1: if (c == CL_A) t = one(ST_F2, AC_CONSUME);
      ST_F2: if (c == CL_L) t = one(ST_F3, AC_CONSUME);
      ST_F3: if (c == CL_S) t = one(ST_F4, AC_CONSUME);
      ST_F4: if (c == CL_E) t = one(ST_ENDVAL, AC_RFALSE);
      ST_A1: if (c == CL_R) t = one(ST_A2, AC_CONSUME);
      ST_A2: if (c == CL_R) t = one(ST_A3, AC_CONSUME);
      ST_A3: if (c == CL_A) t = one(ST_A4, AC_CONSUME);
      ST_A4: if (c == CL_Y) t = one(ST_A5, AC_CONSUME);
      ST_A5: if (c == CL_LPAREN) t = two(ST_MATRIX, AC_CONSUME, AC_BMAT);
      ST_MATRIX: t = (c == CL_RPAREN) ? one(ST_ENDVAL, AC_EMAT) : one(ST_MATRIX, AC_CONSUME);
      default: ;
    endcase
    return t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    trans_t      want;
    int unsigned errs;
    if (!rst_ni) begin
      lexer_state <= ST_START;
      expected_trans.delete();
      taken_cnt    <= 0;
      results_o    <= 0;
      fail_count_o <= 0;
    end else begin
      errs = 0;
      // Results are matched before new items are queued; no result may
      // leave in the same cycle as its own item.
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (expected_trans.size() == 0) begin
          $error("result with no item waiting: next_state %0d", next_state_i);
          errs++;
        end else begin
          want = expected_trans.pop_front();
          if (next_state_i !== want.next_state) begin
            $error("next_state: expected %0d, actual %0d", want.next_state, next_state_i);
            errs++;
          end
          if (first_action_i !== want.first_action) begin
            $error("first_action: expected %0d, actual %0d", want.first_action,
                   first_action_i);
            errs++;
          end
          if (second_action_i !== want.second_action) begin
            $error("second_action: expected %0d, actual %0d", want.second_action,
                   second_action_i);
            errs++;
          end
          if (has_second_i !== want.has_second) begin
            $error("has_second: expected %0d, actual %0d", want.has_second, has_second_i);
            errs++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = next_transition(lexer_state, char_class_i);
        expected_trans.push_back(want);
        lexer_state <= want.next_state;
        taken_cnt   <= taken_cnt + 1;
      end
      fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// JSON lexer transition unit testbench
// Feeds the unit a short hand-written document, then long random streams of
// well-formed JSON fragments with random string and matrix bodies, and ends
// with a malformed tail that drives the lexer into its error state. Both
// sides idle and stall at random; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import jcct_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseChars    = 530;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned TailChars     = 40;
  localparam logic [4:0]  ClassTop      = 5'd31;

  typedef enum logic [1:0] {G_START, G_KEY, G_VALUE, G_ENDVAL} text_pos_e;

  // Opening document: blanks, a signed float with exponent, a key with an
  // out-of-range class in it, a matrix, then end of file.
  localparam logic [4:0] OPENING_DOC [25] = '{
    CL_SPACE, CL_WHITE, CL_LBRACK, CL_MINUS, CL_ZERO, CL_DOT, CL_DIGIT, CL_BIGE,
    CL_PLUS, CL_DIGIT, CL_COMMA, CL_LBRACE, CL_DQUOTE, ClassTop, CL_DQUOTE,
    CL_COLON, CL_A, CL_R, CL_R, CL_A, CL_Y, CL_LPAREN, CL_RPAREN, CL_RBRACE,
    CL_EOF
  };

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [4:0] char_class = '0;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [4:0] next_state;
  logic [4:0] first_action;
  logic [4:0] second_action;
  logic       has_second;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;

  logic [4:0]  text_q [$];
  text_pos_e   text_pos       = G_START;
  int unsigned fragments      = 0;
  int unsigned chars_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_start     = 1'b0;
  logic        hold_done      = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;

  always #10 clk = ~clk;

  json_char_class_transition_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .char_class_i    (char_class),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .next_state_o    (next_state),
    .first_action_o  (first_action),
    .second_action_o (second_action),
    .has_second_o    (has_second)
  );

  lexer_transition_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .char_class_i    (char_class),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .next_state_i    (next_state),
    .first_action_i  (first_action),
    .second_action_i (second_action),
    .has_second_i    (has_second),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .results_o       (results)
  );

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_start && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HoldCycles - 1;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void add_blanks();
    repeat ($urandom_range(0, 2)) text_q.push_back($urandom_range(1) ? CL_SPACE : CL_WHITE);
  endfunction

  // Any class but the closing one, the out-of-range codes included.
  function automatic void add_body(input logic [4:0] stop);
    logic [4:0] raw;
    repeat ($urandom_range(0, 6)) begin
      do raw = 5'($urandom_range(31)); while (raw == stop);
      text_q.push_back(raw);
    end
  endfunction

  function automatic void add_digits(input int unsigned most);
    repeat ($urandom_range(0, most)) text_q.push_back($urandom_range(1) ? CL_ZERO : CL_DIGIT);
  endfunction

  // Appends one well-formed fragment that the lexer accepts from text_pos.
  function automatic void grow_text();
    int unsigned pick;
    logic [4:0]  lead;
    fragments++;
    add_blanks();
    case (text_pos)
      G_START: begin
        if ($urandom_range(1)) begin
          text_q.push_back(CL_LBRACE);
          text_pos = G_KEY;
        end else begin
          text_q.push_back(CL_LBRACK);
          text_pos = G_VALUE;
        end
      end
      G_KEY: begin
        text_q.push_back(CL_DQUOTE);
        add_body(CL_DQUOTE);
        text_q.push_back(CL_DQUOTE);
        text_pos = G_ENDVAL;
      end
      G_VALUE: begin
        pick = $urandom_range(0, 9);
        text_pos = G_ENDVAL;
        case (pick)
          0: begin
            text_q.push_back(CL_DQUOTE);
            add_body(CL_DQUOTE);
            text_q.push_back(CL_DQUOTE);
          end
          1, 2: begin
            case ($urandom_range(0, 4))
              0:       lead = CL_MINUS;
              1:       lead = CL_PLUS;
              2:       lead = CL_ZERO;
              3:       lead = CL_DIGIT;
              default: lead = CL_DOT;
            endcase
            text_q.push_back(lead);
            if (lead == CL_DOT) begin
              add_digits(3);
            end else begin
              add_digits(4);
              if ($urandom_range(2) == 0) begin
                text_q.push_back(CL_DOT);
                add_digits(3);
              end
            end
            if ($urandom_range(2) == 0) begin
              text_q.push_back($urandom_range(1) ? CL_E : CL_BIGE);
              case ($urandom_range(0, 3))
                0:       text_q.push_back(CL_MINUS);
                1:       text_q.push_back(CL_PLUS);
                2:       text_q.push_back(CL_ZERO);
                default: text_q.push_back(CL_DIGIT);
              endcase
              add_digits(2);
            end
            // A number must be closed directly, without blanks.
            case ($urandom_range(0, 2))
              0: begin
                text_q.push_back(CL_COMMA);
                text_pos = G_VALUE;
              end
              1:       text_q.push_back(CL_RBRACK);
              default: text_q.push_back(CL_RBRACE);
            endcase
          end
          3: text_q = {text_q, CL_T, CL_R, CL_U, CL_E};
          4: text_q = {text_q, CL_N, CL_U, CL_L, CL_L};
          5: text_q = {text_q, CL_F, CL_A, CL_L, CL_S, CL_E};
          6: begin
            text_q = {text_q, CL_A, CL_R, CL_R, CL_A, CL_Y, CL_LPAREN};
            add_body(CL_RPAREN);
            text_q.push_back(CL_RPAREN);
          end
          7: begin
            text_q.push_back(CL_LBRACE);
            text_pos = G_KEY;
          end
          8: begin
            text_q.push_back(CL_LBRACK);
            text_pos = G_VALUE;
          end
          default: text_q.push_back(CL_RBRACK);
        endcase
      end
      default: begin
        case ($urandom_range(0, 5))
          0, 1: begin
            text_q.push_back(CL_COMMA);
            text_pos = G_VALUE;
          end
          2: begin
            text_q.push_back(CL_COLON);
            text_pos = G_VALUE;
          end
          3:       text_q.push_back(CL_RBRACE);
          4:       text_q.push_back(CL_RBRACK);
          default: text_q.push_back(CL_EOF);
        endcase
      end
    endcase
  endfunction

  task automatic send_char(input logic [4:0] cls);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    char_class <= cls;
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  task automatic send_stream(input int unsigned count);
    int unsigned n;
    n = 0;
    while (n < count) begin
      if (text_q.size() == 0) grow_text();
      send_char(text_q.pop_front());
      n++;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (OPENING_DOC[i]) send_char(OPENING_DOC[i]);
    text_pos = G_ENDVAL;

    send_idle_pct = 30;
    recv_stall_pct <= 88;
    send_stream(PhaseChars);
    drain_results();

    send_idle_pct = 88;
    recv_stall_pct <= 30;
    send_stream(PhaseChars);
    drain_results();

    // Full rate with one long receiver hold-off, so the input backs up.
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    hold_start <= 1'b1;
    send_stream(PhaseChars);
    while (text_q.size() != 0) send_char(text_q.pop_front());

    // Broken tail: a misspelled word or a stray character, then noise that
    // the error state must keep answering with abort.
    if (text_pos == G_VALUE) text_q = {CL_T, CL_R, CL_A};
    else text_q = {CL_OTHER};
    repeat (TailChars) text_q.push_back(5'($urandom_range(31)));
    while (text_q.size() != 0) send_char(text_q.pop_front());

    drain_results();
    repeat (8) @(posedge clk);

    $display("Run covered %0d characters in %0d generated JSON fragments and %0d checked",
             chars_sent, fragments, results);
    $display("transitions, under mixed idling, a long output hold-off and a malformed tail.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/jcct_pkg.sv
sv/jcct_decode.sv
sv/json_char_class_transition_unit.sv
sv/jcct_checker.sv
verif/lexer_transition_checker.sv
verif/tb_top.sv
